@@ rtl/core/spn_pkg.sv @@
// spn_pkg: shared types, constants and table functions of the spn block cipher core
// used by spn_cfg, spn_round and spn_block_cipher_core; no dependencies
package spn_pkg;

    localparam int SBOX_W     = 4;
    localparam int BLOCK_W    = 16;
    localparam int MAX_ROUNDS = 12;
    localparam int TAB_N      = 1 << SBOX_W;
    localparam int GROUPS     = BLOCK_W / SBOX_W;
    localparam int POS_W      = $clog2(BLOCK_W);
    localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
    localparam int KEY_W      = 64;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int IDX_LSB    = 3;

    localparam logic [63:0] TABLE_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [3:0]  ROUNDS_RESET = 4'd4;

    typedef enum logic [1:0] {
        REG_SBOX   = 2'd0,
        REG_PERM   = 2'd1,
        REG_KEY    = 2'd2,
        REG_ROUNDS = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    typedef logic [TAB_N-1:0][SBOX_W-1:0]   sbox_tab_t;
    typedef logic [BLOCK_W-1:0][POS_W-1:0]  perm_tab_t;

    typedef struct packed {
        sbox_tab_t        sbox;
        sbox_tab_t        sbox_inv;
        perm_tab_t        perm;
        perm_tab_t        perm_inv;
        logic [KEY_W-1:0] key;
        logic [3:0]       rounds;
    } cfg_t;

    typedef struct packed {
        logic               decrypt;
        logic               first;
        logic               last;
        logic [BLOCK_W-1:0] key_round;
        logic [BLOCK_W-1:0] key_final;
    } round_ctl_t;

    function automatic sbox_tab_t sbox_invert(input sbox_tab_t s);
        sbox_tab_t inv;
        inv = '0;
        for (int w = 0; w < TAB_N; w++) begin
            for (int v = 0; v < TAB_N; v++) begin
                if (s[v] == SBOX_W'(w)) begin
                    inv[w] = SBOX_W'(v);
                end
            end
        end
        return inv;
    endfunction

    function automatic perm_tab_t perm_invert(input perm_tab_t p);
        perm_tab_t inv;
        inv = '0;
        for (int q = 0; q < BLOCK_W; q++) begin
            for (int i = 0; i < BLOCK_W; i++) begin
                if (p[i] == POS_W'(q)) begin
                    inv[q] = POS_W'(i);
                end
            end
        end
        return inv;
    endfunction

    function automatic logic [BLOCK_W-1:0] substitute(input logic [BLOCK_W-1:0] x,
                                                      input sbox_tab_t s);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int j = 0; j < GROUPS; j++) begin
            y[j*SBOX_W +: SBOX_W] = s[x[j*SBOX_W +: SBOX_W]];
        end
        return y;
    endfunction

    // output position i takes input position p[i]; position 0 is the msb
    function automatic logic [BLOCK_W-1:0] permute(input logic [BLOCK_W-1:0] x,
                                                   input perm_tab_t p);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[BLOCK_W-1-i] = x[POS_W'(BLOCK_W-1) - p[i]];
        end
        return y;
    endfunction

    // window of the key starting SBOX_W*r bits below its msb
    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] key,
                                                     input logic [CNT_W-1:0] r);
        logic [KEY_W-1:0] sh;
        logic [5:0]       amt;
        amt = 6'(KEY_W - BLOCK_W) - 6'(r * SBOX_W);
        sh  = key >> amt;
        return sh[BLOCK_W-1:0];
    endfunction

endpackage

@@ rtl/core/spn_block_cipher_core.sv @@
// spn_block_cipher_core: top level of the 16-bit spn cipher with round sequencer
// instantiates spn_cfg and spn_round; depends on spn_pkg
//
// One item (func, data_in) is accepted while the core is idle; it then runs one
// round per clock through the single shared round unit, for Nr rounds
// (Nr = round_count, zero read as one, above twelve read as twelve), and
// the result is loaded into the output register at the end of the last round.
// The next item can be accepted the cycle after that, while the result still
// waits in the output register; a result that cannot be loaded because the
// previous one was not taken holds the core in its last round. A new item is
// not accepted while an item is still running.
module spn_block_cipher_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [15:0]                 data_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 data_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spn_pkg::ADDR_W-1:0]  paddr,
    input  logic [spn_pkg::DATA_W-1:0]  pwdata,
    output logic [spn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    spn_pkg::cfg_t               cfg;
    spn_pkg::round_ctl_t         ctl;
    spn_pkg::state_t             state_reg, state_next;
    logic [spn_pkg::CNT_W-1:0]   step_reg, step_next;
    logic [spn_pkg::CNT_W-1:0]   nr_reg, nr_next;
    logic                        dec_reg, dec_next;
    logic [15:0]                 x_reg, x_next;
    logic [15:0]                 out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;
    logic [15:0]                 round_y;
    logic [spn_pkg::CNT_W-1:0]   nr_sat;
    logic [spn_pkg::CNT_W-1:0]   key_sel;
    logic                        in_acc;
    logic                        out_free;

    spn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spn_round u_round (
        .cfg (cfg),
        .ctl (ctl),
        .x   (x_reg),
        .y   (round_y)
    );

    always_comb begin
        if (cfg.rounds == 4'd0) begin
            nr_sat = spn_pkg::CNT_W'(1);
        end else if (cfg.rounds > 4'(spn_pkg::MAX_ROUNDS)) begin
            nr_sat = spn_pkg::CNT_W'(spn_pkg::MAX_ROUNDS);
        end else begin
            nr_sat = spn_pkg::CNT_W'(cfg.rounds);
        end
    end

    assign key_sel       = dec_reg ? (nr_reg - spn_pkg::CNT_W'(1) - step_reg) : step_reg;
    assign ctl.decrypt   = dec_reg;
    assign ctl.first     = (step_reg == '0);
    assign ctl.last      = (step_reg == nr_reg - spn_pkg::CNT_W'(1));
    assign ctl.key_round = spn_pkg::round_key(cfg.key, key_sel);
    assign ctl.key_final = spn_pkg::round_key(cfg.key, nr_reg);

    assign in_stall  = (state_reg != spn_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign data_out  = out_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        nr_next        = nr_reg;
        dec_next       = dec_reg;
        x_next         = x_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            spn_pkg::ST_IDLE: begin
                if (in_acc) begin
                    state_next = spn_pkg::ST_RUN;
                    step_next  = '0;
                    nr_next    = nr_sat;
                    dec_next   = func;
                    x_next     = data_in;
                end
            end
            spn_pkg::ST_RUN: begin
                if (ctl.last) begin
                    if (out_free) begin
                        out_next       = round_y;
                        out_valid_next = 1'b1;
                        state_next     = spn_pkg::ST_IDLE;
                    end
                end else begin
                    x_next    = round_y;
                    step_next = step_reg + spn_pkg::CNT_W'(1);
                end
            end
            default: state_next = spn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= spn_pkg::ST_IDLE;
            step_reg      <= '0;
            nr_reg        <= spn_pkg::CNT_W'(1);
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nr_reg        <= nr_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        x_reg   <= x_next;
        out_reg <= out_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("core not busy after accepting an item");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spn_pkg::ST_RUN |-> step_reg < nr_reg)
        else $error("round step beyond round count");

    a_nr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spn_pkg::ST_RUN |->
            (nr_reg != '0) && (nr_reg <= spn_pkg::CNT_W'(spn_pkg::MAX_ROUNDS)))
        else $error("latched round count out of range");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == spn_pkg::ST_RUN))
        else $error("result loaded without a running item");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spn_pkg::ST_RUN) && ctl.last && out_free
            |=> state_reg == spn_pkg::ST_IDLE && out_valid_reg)
        else $error("core did not return to idle after delivering a result");

endmodule

@@ rtl/core/spn_cfg.sv @@
// spn_cfg: apb register file holding s-box, permutation, key and round count
// also keeps registered inverse tables; depends on spn_pkg
module spn_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spn_pkg::ADDR_W-1:0]  paddr,
    input  logic [spn_pkg::DATA_W-1:0]  pwdata,
    output logic [spn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output spn_pkg::cfg_t               cfg
);

    logic [63:0]         sbox_reg;
    logic [63:0]         perm_reg;
    logic [63:0]         key_reg;
    logic [3:0]          rounds_reg;
    spn_pkg::sbox_tab_t  sbox_inv_reg;
    spn_pkg::perm_tab_t  perm_inv_reg;
    spn_pkg::reg_idx_t   idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = spn_pkg::reg_idx_t'(paddr[spn_pkg::ADDR_W-1:spn_pkg::IDX_LSB]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sbox_reg     <= spn_pkg::TABLE_RESET;
            perm_reg     <= spn_pkg::TABLE_RESET;
            key_reg      <= '0;
            rounds_reg   <= spn_pkg::ROUNDS_RESET;
            sbox_inv_reg <= spn_pkg::TABLE_RESET;
            perm_inv_reg <= spn_pkg::TABLE_RESET;
        end else begin
            sbox_inv_reg <= spn_pkg::sbox_invert(sbox_reg);
            perm_inv_reg <= spn_pkg::perm_invert(perm_reg);
            if (wr_en) begin
                unique case (idx)
                    spn_pkg::REG_SBOX:   sbox_reg   <= pwdata;
                    spn_pkg::REG_PERM:   perm_reg   <= pwdata;
                    spn_pkg::REG_KEY:    key_reg    <= pwdata;
                    spn_pkg::REG_ROUNDS: rounds_reg <= pwdata[3:0];
                    default:             ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (idx)
            spn_pkg::REG_SBOX:   prdata = sbox_reg;
            spn_pkg::REG_PERM:   prdata = perm_reg;
            spn_pkg::REG_KEY:    prdata = key_reg;
            spn_pkg::REG_ROUNDS: prdata = {60'd0, rounds_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.sbox     = sbox_reg;
    assign cfg.perm     = perm_reg;
    assign cfg.sbox_inv = sbox_inv_reg;
    assign cfg.perm_inv = perm_inv_reg;
    assign cfg.key      = key_reg;
    assign cfg.rounds   = rounds_reg;

endmodule

@@ rtl/core/spn_round.sv @@
// spn_round: shared round unit, one encrypt or decrypt round per use
// depends on spn_pkg
module spn_round (
    input  spn_pkg::cfg_t                  cfg,
    input  spn_pkg::round_ctl_t            ctl,
    input  logic [spn_pkg::BLOCK_W-1:0]    x,
    output logic [spn_pkg::BLOCK_W-1:0]    y
);

    logic [spn_pkg::BLOCK_W-1:0] enc_sub;
    logic [spn_pkg::BLOCK_W-1:0] enc_out;
    logic [spn_pkg::BLOCK_W-1:0] dec_pre;
    logic [spn_pkg::BLOCK_W-1:0] dec_out;

    // encrypt: key mix, s-boxes, then permutation or final key mix
    assign enc_sub = spn_pkg::substitute(x ^ ctl.key_round, cfg.sbox);
    assign enc_out = ctl.last ? (enc_sub ^ ctl.key_final)
                              : spn_pkg::permute(enc_sub, cfg.perm);

    // decrypt: first step undoes the final key mix, later ones the permutation
    assign dec_pre = ctl.first ? (x ^ ctl.key_final)
                               : spn_pkg::permute(x, cfg.perm_inv);
    assign dec_out = spn_pkg::substitute(dec_pre, cfg.sbox_inv) ^ ctl.key_round;

    assign y = ctl.decrypt ? dec_out : enc_out;

endmodule
